/* rtl/tmc_pkg.sv */
// Package for the tape machine core: sizes, character codes, command
// and state encodings, and the status bundle between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tmc_pkg;

  localparam int TAPE_DEPTH    = 4096;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int STACK_DEPTH   = 64;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
  localparam int CNT_W   = PROG_AW + 1;
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int LVL_W   = STK_AW + 1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_END   = 2'd2,
    ACT_EXEC  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_OK   = 3'd0,
    STS_END  = 3'd1,
    STS_LOOP = 3'd2,
    STS_OVF  = 3'd3,
    STS_FULL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_ADD  = 2'd1,
    RUN_MOVE = 2'd2
  } run_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_MOVE, OP_OPEN, OP_CLOSE, OP_OUT, OP_IN, OP_OTHER
  } op_e;

  typedef enum logic [2:0] {
    OPN_CLEAR, OPN_SCAN, OPN_ERR, OPN_OVF, OPN_PUSH, OPN_SKIP
  } open_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_CLR_INIT, CMD_CLR_STEP, CMD_LOAD, CMD_FLUSH,
    CMD_WRITE, CMD_EX0, CMD_EX1, CMD_EX2, CMD_EX3, CMD_RET, CMD_SCAN_N,
    CMD_SCAN_CHK, CMD_SCAN_WAIT, CMD_SKIP_RD, CMD_SKIP_OP, CMD_NRI_RD,
    CMD_PUBLISH
  } cmd_e;

  typedef enum logic [3:0] {
    S_RST_CLR, S_IDLE, S_DISPATCH, S_CLR, S_WRITE, S_EX1, S_EX2, S_EX3,
    S_RET, S_SCAN_N, S_SCAN_CHK, S_SCAN_WAIT, S_SKIP_RD, S_SKIP_OP,
    S_NRI_RD, S_NRI
  } state_e;

  typedef struct packed {
    action_e action;
    logic    clr_last;
    logic    wb_empty;
    logic    pc_end;
    op_e     op_now;
    op_e     op_held;
    logic    close_ret;
    open_e   open_kind;
    logic    scan_done;
    logic    skip_end;
    logic    skip_close;
  } dp_status_t;

  function automatic op_e decode_op(logic [7:0] b);
    op_e o;
    unique case (b)
      CH_PLUS:  o = OP_ADD;
      CH_GT:    o = OP_MOVE;
      CH_OPEN:  o = OP_OPEN;
      CH_CLOSE: o = OP_CLOSE;
      CH_DOT:   o = OP_OUT;
      CH_COMMA: o = OP_IN;
      default:  o = OP_OTHER;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/tmc_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface tmc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       next_reads_input;
  modport source (output valid, status, out_valid, out_byte, next_reads_input,
                  input ready);
  modport sink (input valid, status, out_valid, out_byte, next_reads_input,
                output ready);
endinterface
`default_nettype wire

/* rtl/tmc_datapath.sv */
// Datapath: program, tape and return stack memories, machine registers,
// the run compiler and the result registers. Depends on tmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmc_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tmc_pkg::cmd_e      cmd_i,
  input  wire logic [1:0]         action_i,
  input  wire logic [7:0]         data_byte_i,
  output tmc_pkg::dp_status_t     status_o,
  output logic [2:0]              res_status_o,
  output logic                    res_out_valid_o,
  output logic [7:0]              res_out_byte_o,
  output logic                    res_nri_o
);
  import tmc_pkg::*;

  logic [7:0] prog_mem [PROGRAM_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];
  logic [PROG_AW-1:0] stk_mem [STACK_DEPTH];

  logic [7:0] prog_rd_q, tape_rd_q;
  logic [PROG_AW-1:0] stk_rd_q;

  logic prog_we, prog_re, tape_we, tape_re, stk_we, stk_re;
  logic [PROG_AW-1:0] prog_wa, prog_ra, stk_wd;
  logic [7:0] prog_wd, tape_wd;
  logic [TAPE_AW-1:0] tape_wa, tape_ra;
  logic [STK_AW-1:0] stk_wa, stk_ra;

  action_e act_q;
  logic [7:0] db_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, sa_q, sa_d;
  logic [TAPE_AW-1:0] ptr_q, ptr_d, clr_q, clr_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  run_e run_kind_q, run_kind_d;
  logic [7:0] run_off_q, run_off_d;
  logic [7:0] wb_q [3];
  logic [7:0] wb_d [3];
  logic [1:0] wb_n_q, wb_n_d;
  status_e st_q, st_d;
  logic ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic [7:0] cell_q, cell_d, n1_q, n1_d, scan_n_q, scan_n_d;
  logic [TAPE_AW:0] scan_i_q, scan_i_d;
  logic [CNT_W-1:0] q_q, q_d, depth_q, depth_d;
  op_e op_q, op_d;

  logic [CNT_W-1:0] sa_p1, sa_p2, sa_p3, sa_p4;
  logic [7:0] n1_v, b3;
  logic micro;
  open_e open_kind;
  op_e skip_op;
  logic [CNT_W-1:0] depth_n, q_n;

  run_e c_kind;
  logic [8:0] d9, sum9;
  logic do_flush, char_emit, emit1, emit2, ok1, ok2;
  run_e flush_kind, new_kind;
  logic [7:0] flush_off, new_off, flush_op;
  logic [CNT_W:0] cnt1;

  assign sa_p1 = sa_q + CNT_W'(1);
  assign sa_p2 = sa_q + CNT_W'(2);
  assign sa_p3 = sa_q + CNT_W'(3);
  assign sa_p4 = sa_q + CNT_W'(4);
  assign n1_v  = (sa_p1 < cnt_q) ? prog_rd_q : 8'd0;
  assign b3    = prog_rd_q;
  assign micro = (sa_p3 < cnt_q) && (b3 == CH_CLOSE) &&
                 ((n1_q == CH_PLUS) || (n1_q == CH_GT));
  assign skip_op = decode_op(prog_rd_q);
  assign q_n = q_q + ((skip_op == OP_ADD || skip_op == OP_MOVE) ?
                      CNT_W'(2) : CNT_W'(1));

  always_comb begin
    depth_n = depth_q;
    if (skip_op == OP_OPEN) begin
      depth_n = depth_q + CNT_W'(1);
    end else if (skip_op == OP_CLOSE) begin
      depth_n = depth_q - CNT_W'(1);
    end
  end

  always_comb begin
    if (micro && n1_q == CH_PLUS) begin
      open_kind = OPN_CLEAR;
    end else if (micro) begin
      open_kind = OPN_SCAN;
    end else if (n1_q == CH_CLOSE && cell_q != 8'd0) begin
      open_kind = OPN_ERR;
    end else if (cell_q != 8'd0) begin
      open_kind = (lvl_q == LVL_W'(STACK_DEPTH)) ? OPN_OVF : OPN_PUSH;
    end else begin
      open_kind = OPN_SKIP;
    end
  end

  // Run compiler: what one loaded character, or end of load, emits.
  always_comb begin
    c_kind    = RUN_NONE;
    d9        = 9'd1;
    char_emit = 1'b0;
    if (db_q == CH_PLUS) begin
      c_kind = RUN_ADD;
    end else if (db_q == CH_MINUS) begin
      c_kind = RUN_ADD;
      d9 = 9'h1FF;
    end else if (db_q == CH_GT) begin
      c_kind = RUN_MOVE;
    end else if (db_q == CH_LT) begin
      c_kind = RUN_MOVE;
      d9 = 9'h1FF;
    end
    if (cmd_i == CMD_FLUSH) begin
      c_kind = RUN_NONE;
    end
    sum9       = {run_off_q[7], run_off_q} + d9;
    do_flush   = (run_kind_q != RUN_NONE) && (run_off_q != 8'd0);
    flush_kind = run_kind_q;
    flush_off  = run_off_q;
    new_kind   = RUN_NONE;
    new_off    = 8'd0;
    if (c_kind != RUN_NONE) begin
      if (run_kind_q != c_kind) begin
        new_kind = c_kind;
        new_off  = d9[7:0];
      end else if ($signed(sum9) >= 9'sd127 || $signed(sum9) <= -9'sd127) begin
        do_flush  = 1'b1;
        flush_off = sum9[7:0];
      end else begin
        do_flush = 1'b0;
        new_kind = c_kind;
        new_off  = sum9[7:0];
      end
    end else if (cmd_i == CMD_LOAD) begin
      char_emit = (db_q == CH_OPEN) || (db_q == CH_CLOSE) ||
                  (db_q == CH_DOT) || (db_q == CH_COMMA);
    end
    flush_op = (flush_kind == RUN_ADD) ? CH_PLUS : CH_GT;
    ok1   = ({1'b0, cnt_q} + (CNT_W+1)'(2)) <= (CNT_W+1)'(PROGRAM_DEPTH);
    emit1 = do_flush && ok1;
    cnt1  = {1'b0, cnt_q} + (emit1 ? (CNT_W+1)'(2) : (CNT_W+1)'(0));
    ok2   = (cnt1 + (CNT_W+1)'(1)) <= (CNT_W+1)'(PROGRAM_DEPTH);
    emit2 = char_emit && ok2;
  end

  always_comb begin
    cnt_d = cnt_q; sa_d = sa_q; ptr_d = ptr_q; clr_d = clr_q; lvl_d = lvl_q;
    run_kind_d = run_kind_q; run_off_d = run_off_q;
    wb_d = wb_q; wb_n_d = wb_n_q;
    st_d = st_q; ov_d = ov_q; ob_d = ob_q;
    cell_d = cell_q; n1_d = n1_q; scan_n_d = scan_n_q; scan_i_d = scan_i_q;
    q_d = q_q; depth_d = depth_q; op_d = op_q;
    prog_we = 1'b0; prog_wa = cnt_q[PROG_AW-1:0]; prog_wd = wb_q[0];
    prog_re = 1'b0; prog_ra = sa_q[PROG_AW-1:0];
    tape_we = 1'b0; tape_wa = ptr_q; tape_wd = 8'd0;
    tape_re = 1'b0; tape_ra = ptr_q;
    stk_we = 1'b0; stk_wa = lvl_q[STK_AW-1:0]; stk_wd = sa_q[PROG_AW-1:0];
    stk_re = 1'b0; stk_ra = STK_AW'(lvl_q - LVL_W'(1));
    unique case (cmd_i)
      CMD_NONE, CMD_PUBLISH: begin
      end
      CMD_ACCEPT: begin
        st_d = STS_OK;
        ov_d = 1'b0;
        ob_d = 8'd0;
      end
      CMD_CLR_INIT: begin
        cnt_d = '0; sa_d = '0; ptr_d = '0; lvl_d = '0; clr_d = '0;
        run_kind_d = RUN_NONE; run_off_d = 8'd0;
      end
      CMD_CLR_STEP: begin
        tape_we = 1'b1;
        tape_wa = clr_q;
        clr_d = clr_q + TAPE_AW'(1);
      end
      CMD_LOAD, CMD_FLUSH: begin
        run_kind_d = new_kind;
        run_off_d  = new_off;
        if (emit1) begin
          wb_d[0] = flush_op;
          wb_d[1] = flush_off;
          wb_d[2] = db_q;
        end else begin
          wb_d[0] = db_q;
        end
        wb_n_d = {emit1, 1'b0} + {1'b0, emit2};
        st_d = ((do_flush && !ok1) || (char_emit && !ok2)) ? STS_FULL : STS_OK;
      end
      CMD_WRITE: begin
        prog_we = 1'b1;
        cnt_d   = cnt_q + CNT_W'(1);
        wb_d[0] = wb_q[1];
        wb_d[1] = wb_q[2];
        wb_n_d  = wb_n_q - 2'd1;
      end
      CMD_EX0: begin
        if (sa_q >= cnt_q) begin
          st_d = STS_END;
        end else begin
          prog_re = 1'b1;
          tape_re = 1'b1;
        end
      end
      CMD_EX1: begin
        cell_d = tape_rd_q;
        op_d   = status_o.op_now;
        unique case (status_o.op_now)
          OP_ADD, OP_MOVE, OP_OPEN: begin
            prog_re = 1'b1;
            prog_ra = sa_p1[PROG_AW-1:0];
          end
          OP_OUT: begin
            ov_d = 1'b1;
            ob_d = tape_rd_q;
            sa_d = sa_p1;
          end
          OP_IN: begin
            tape_we = 1'b1;
            tape_wd = db_q;
            sa_d = sa_p1;
          end
          OP_CLOSE: begin
            if (status_o.close_ret) begin
              stk_re = 1'b1;
            end else begin
              if (lvl_q != '0) begin
                lvl_d = lvl_q - LVL_W'(1);
              end
              sa_d = sa_p1;
            end
          end
          default: sa_d = sa_p1;
        endcase
      end
      CMD_EX2: begin
        unique case (op_q)
          OP_ADD: begin
            tape_we = (sa_p1 < cnt_q);
            tape_wd = cell_q + n1_v;
            sa_d = sa_p2;
          end
          OP_MOVE: begin
            if (sa_p1 < cnt_q) begin
              ptr_d = ptr_q + {{(TAPE_AW-8){n1_v[7]}}, n1_v};
            end
            sa_d = sa_p2;
          end
          default: begin
            n1_d = n1_v;
            prog_re = 1'b1;
            prog_ra = sa_p3[PROG_AW-1:0];
          end
        endcase
      end
      CMD_EX3: begin
        unique case (open_kind)
          OPN_CLEAR: begin
            tape_we = 1'b1;
            sa_d = sa_p4;
          end
          OPN_SCAN: begin
            prog_re = 1'b1;
            prog_ra = sa_p2[PROG_AW-1:0];
            scan_i_d = '0;
          end
          OPN_ERR: st_d = STS_LOOP;
          OPN_OVF: st_d = STS_OVF;
          OPN_PUSH: begin
            stk_we = 1'b1;
            lvl_d = lvl_q + LVL_W'(1);
            sa_d = sa_p1;
          end
          default: begin
            q_d = sa_p1;
            depth_d = CNT_W'(1);
          end
        endcase
      end
      CMD_RET: sa_d = {1'b0, stk_rd_q} + CNT_W'(1);
      CMD_SCAN_N: scan_n_d = prog_rd_q;
      CMD_SCAN_CHK: begin
        if (cell_q == 8'd0) begin
          sa_d = sa_p4;
        end else if (scan_i_q == (TAPE_AW+1)'(TAPE_DEPTH)) begin
          st_d = STS_LOOP;
        end else begin
          ptr_d = ptr_q + {{(TAPE_AW-8){scan_n_q[7]}}, scan_n_q};
          scan_i_d = scan_i_q + (TAPE_AW+1)'(1);
          tape_re = 1'b1;
          tape_ra = ptr_d;
        end
      end
      CMD_SCAN_WAIT: cell_d = tape_rd_q;
      CMD_SKIP_RD: begin
        if (q_q >= cnt_q) begin
          sa_d = cnt_q;
        end else begin
          prog_re = 1'b1;
          prog_ra = q_q[PROG_AW-1:0];
        end
      end
      CMD_SKIP_OP: begin
        if (depth_n == '0) begin
          sa_d = (q_n < cnt_q) ? q_n : cnt_q;
        end else begin
          q_d = q_n;
          depth_d = depth_n;
        end
      end
      CMD_NRI_RD: prog_re = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sa_q <= '0; ptr_q <= '0; clr_q <= '0; lvl_q <= '0;
      run_kind_q <= RUN_NONE; run_off_q <= 8'd0; wb_n_q <= 2'd0;
      st_q <= STS_OK; ov_q <= 1'b0; act_q <= ACT_CLEAR;
      scan_i_q <= '0; depth_q <= '0; q_q <= '0; op_q <= OP_OTHER;
    end else begin
      cnt_q <= cnt_d; sa_q <= sa_d; ptr_q <= ptr_d; clr_q <= clr_d;
      lvl_q <= lvl_d; run_kind_q <= run_kind_d; run_off_q <= run_off_d;
      wb_n_q <= wb_n_d; st_q <= st_d; ov_q <= ov_d;
      scan_i_q <= scan_i_d; depth_q <= depth_d; q_q <= q_d; op_q <= op_d;
      if (cmd_i == CMD_ACCEPT) begin
        act_q <= action_e'(action_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q <= wb_d; ob_q <= ob_d; cell_q <= cell_d; n1_q <= n1_d;
    scan_n_q <= scan_n_d;
    if (cmd_i == CMD_ACCEPT) begin
      db_q <= data_byte_i;
    end
    if (cmd_i == CMD_PUBLISH) begin
      res_status_o    <= st_q;
      res_out_valid_o <= ov_q;
      res_out_byte_o  <= ob_q;
      res_nri_o       <= (sa_q < cnt_q) && (prog_rd_q == CH_COMMA);
    end
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_wa] <= prog_wd;
    end
    if (prog_re) begin
      prog_rd_q <= prog_mem[prog_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (tape_re) begin
      tape_rd_q <= tape_mem[tape_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  always_comb begin
    status_o.action     = act_q;
    status_o.clr_last   = (clr_q == TAPE_AW'(TAPE_DEPTH - 1));
    status_o.wb_empty   = (wb_n_q == 2'd0);
    status_o.pc_end     = (sa_q >= cnt_q);
    status_o.op_now     = decode_op(prog_rd_q);
    status_o.op_held    = op_q;
    status_o.close_ret  = (lvl_q != '0) && (tape_rd_q != 8'd0);
    status_o.open_kind  = open_kind;
    status_o.scan_done  = (cell_q == 8'd0) || (scan_i_q == (TAPE_AW+1)'(TAPE_DEPTH));
    status_o.skip_end   = (q_q >= cnt_q);
    status_o.skip_close = (depth_n == '0);
  end

endmodule
`default_nettype wire

/* rtl/tmc_controller.sv */
// Controller state machine: sequences each action over the datapath and
// owns the input and result handshakes. Depends on tmc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmc_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire tmc_pkg::dp_status_t status_i,
  output tmc_pkg::cmd_e            cmd_o
);
  import tmc_pkg::*;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RST_CLR: if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        unique case (status_i.action)
          ACT_CLEAR: state_d = S_CLR;
          ACT_LOAD, ACT_END: state_d = S_WRITE;
          default: state_d = status_i.pc_end ? S_NRI_RD : S_EX1;
        endcase
      end
      S_CLR: if (status_i.clr_last) state_d = S_NRI_RD;
      S_WRITE: if (status_i.wb_empty) state_d = S_NRI_RD;
      S_EX1: begin
        if (status_i.op_now == OP_ADD || status_i.op_now == OP_MOVE ||
            status_i.op_now == OP_OPEN) begin
          state_d = S_EX2;
        end else if (status_i.op_now == OP_CLOSE && status_i.close_ret) begin
          state_d = S_RET;
        end else begin
          state_d = S_NRI_RD;
        end
      end
      S_EX2: state_d = (status_i.op_held == OP_OPEN) ? S_EX3 : S_NRI_RD;
      S_EX3: begin
        if (status_i.open_kind == OPN_SCAN) begin
          state_d = S_SCAN_N;
        end else if (status_i.open_kind == OPN_SKIP) begin
          state_d = S_SKIP_RD;
        end else begin
          state_d = S_NRI_RD;
        end
      end
      S_RET: state_d = S_NRI_RD;
      S_SCAN_N: state_d = S_SCAN_CHK;
      S_SCAN_CHK: state_d = status_i.scan_done ? S_NRI_RD : S_SCAN_WAIT;
      S_SCAN_WAIT: state_d = S_SCAN_CHK;
      S_SKIP_RD: state_d = status_i.skip_end ? S_NRI_RD : S_SKIP_OP;
      S_SKIP_OP: state_d = status_i.skip_close ? S_NRI_RD : S_SKIP_RD;
      S_NRI_RD: state_d = S_NRI;
      S_NRI: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_RST_CLR, S_CLR: cmd_o = CMD_CLR_STEP;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = CMD_ACCEPT;
      end
      S_DISPATCH: begin
        unique case (status_i.action)
          ACT_CLEAR: cmd_o = CMD_CLR_INIT;
          ACT_LOAD:  cmd_o = CMD_LOAD;
          ACT_END:   cmd_o = CMD_FLUSH;
          default:   cmd_o = CMD_EX0;
        endcase
      end
      S_WRITE: if (!status_i.wb_empty) cmd_o = CMD_WRITE;
      S_EX1: cmd_o = CMD_EX1;
      S_EX2: cmd_o = CMD_EX2;
      S_EX3: cmd_o = CMD_EX3;
      S_RET: cmd_o = CMD_RET;
      S_SCAN_N: cmd_o = CMD_SCAN_N;
      S_SCAN_CHK: cmd_o = CMD_SCAN_CHK;
      S_SCAN_WAIT: cmd_o = CMD_SCAN_WAIT;
      S_SKIP_RD: cmd_o = CMD_SKIP_RD;
      S_SKIP_OP: cmd_o = CMD_SKIP_OP;
      S_NRI_RD: cmd_o = CMD_NRI_RD;
      S_NRI: if (slot_free) cmd_o = CMD_PUBLISH;
      default: cmd_o = CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o == CMD_PUBLISH) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/tape_machine_collapsed_op_core_unit.sv */
// Top level of the tape machine core: controller plus datapath.
// Depends on tmc_pkg, tmc_if, tmc_controller and tmc_datapath.
//
//   channel | direction | payload
//   in_i    | sink      | action, data_byte
//   out_o   | source    | status, out_valid, out_byte, next_reads_input
//
// After reset the tape is zeroed cell by cell before the first transfer.
// Before a result is posted, clear all zeroes every tape cell, load and end
// of load write each emitted byte in turn, and an execute step walks its
// states; [>n] adds a tape read per move, a forward skip a program read per
// opcode walked, all set by the single registered read port of each memory.
// A new input is taken while a result waits; a result waits in its register
// when the output is stalled and holds up only the next one.
`timescale 1ns / 1ps
`default_nettype none
module tape_machine_collapsed_op_core_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  tmc_in_if.sink   in_i,
  tmc_out_if.source out_o
);
  import tmc_pkg::*;

  dp_status_t dp_status;
  cmd_e       cmd;

  tmc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  tmc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (in_i.action),
    .data_byte_i     (in_i.data_byte),
    .status_o        (dp_status),
    .res_status_o    (out_o.status),
    .res_out_valid_o (out_o.out_valid),
    .res_out_byte_o  (out_o.out_byte),
    .res_nri_o       (out_o.next_reads_input)
  );

endmodule
`default_nettype wire

/* rtl/tmc_checker.sv */
// Port-level checker for the tape machine core, bound to the top level.
// Depends on tmc_pkg, tape_machine_collapsed_op_core_unit and tmc_if.
`timescale 1ns / 1ps
`default_nettype none
module tmc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_i,
  input wire logic       byte_valid_i,
  input wire logic [7:0] byte_i
);
  import tmc_pkg::*;

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> byte_i == 8'd0)
    else $error("out_byte nonzero without output");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= STS_FULL)
    else $error("status code out of range");

  a_out_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_valid_i |-> status_i == STS_OK)
    else $error("output byte with error status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_i) &&
    $stable(status_i))
    else $error("stalled result changed");

endmodule

bind tape_machine_collapsed_op_core_unit tmc_checker u_tmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .byte_valid_i (out_o.out_valid),
  .byte_i       (out_o.out_byte)
);
`default_nettype wire
